// ===== hdl/cst_pkg.sv =====
`default_nettype none

package cst_pkg;

  localparam int unsigned CmdW     = 3;
  localparam int unsigned IndW     = 2;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned MagW     = 15;
  localparam int unsigned StateW   = 3;
  localparam int unsigned MsW      = 16;
  localparam int unsigned SecW     = 20;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 32;

  // command codes
  localparam logic [CmdW-1:0] CmdCall       = 3'd0;
  localparam logic [CmdW-1:0] CmdSetup      = 3'd1;
  localparam logic [CmdW-1:0] CmdDisconnect = 3'd2;
  localparam logic [CmdW-1:0] CmdTick       = 3'd3;
  localparam logic [CmdW-1:0] CmdSample     = 3'd4;

  // call states
  localparam logic [StateW-1:0] StIdle     = 3'd0;
  localparam logic [StateW-1:0] StIncoming = 3'd1;
  localparam logic [StateW-1:0] StOutgoing = 3'd2;
  localparam logic [StateW-1:0] StActive   = 3'd3;
  localparam logic [StateW-1:0] StEnded    = 3'd4;

  localparam logic [HoldW-1:0] HoldReset   = 16'd2500;
  localparam logic [MsW:0]     MsPerSecond = 17'd1000;
  localparam logic [SecW-1:0]  SecondsMax  = 20'hFFFFF;
  localparam int unsigned      PeakShift   = 7;
  localparam int unsigned      DecayShift  = 3;

  typedef struct packed {
    logic [CmdW-1:0]           cmd;
    logic [IndW-1:0]           indicator_value;
    logic signed [SampleW-1:0] mic_sample;
    logic                      frame_end;
  } item_t;

  typedef struct packed {
    logic [StateW-1:0] call_state;
    logic [SecW-1:0]   call_seconds;
    logic [LevelW-1:0] mic_level;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/cst_in_stage.sv =====
`default_nettype none

module cst_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire cst_pkg::item_t item_i,
  input  wire logic          advance_i,
  output logic               valid_o,
  output cst_pkg::item_t     item_o
);

  logic           valid_q;
  cst_pkg::item_t item_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cst_core.sv =====
`default_nettype none

module cst_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       fire_i,
  input  wire cst_pkg::item_t             item_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [cst_pkg::HoldW-1:0]  cfg_wdata_i,
  output cst_pkg::result_t                result_o
);

  logic [cst_pkg::HoldW-1:0]  hold_q;
  logic [cst_pkg::IndW-1:0]   call_ind_q, call_ind_d;
  logic [cst_pkg::IndW-1:0]   setup_ind_q, setup_ind_d;
  logic [cst_pkg::StateW-1:0] state_q, state_d;
  logic [cst_pkg::MsW-1:0]    elapsed_q, elapsed_d;
  logic [cst_pkg::SecW-1:0]   seconds_q, seconds_d;
  logic [cst_pkg::MagW-1:0]   peak_q, peak_d;
  logic [cst_pkg::LevelW-1:0] meter_q, meter_d;

  logic [cst_pkg::StateW-1:0]  derived;
  logic [cst_pkg::MsW:0]       elapsed_inc;
  logic [cst_pkg::SampleW:0]   neg_mag;
  logic [cst_pkg::MagW-1:0]    mag;
  logic [cst_pkg::MagW-1:0]    peak_max;
  logic [cst_pkg::LevelW-1:0]  frame_lvl;
  logic                        rederive;

  always_comb begin
    call_ind_d  = call_ind_q;
    setup_ind_d = setup_ind_q;
    state_d     = state_q;
    elapsed_d   = elapsed_q;
    seconds_d   = seconds_q;
    peak_d      = peak_q;
    meter_d     = meter_q;
    rederive    = 1'b0;
    derived     = state_q;

    elapsed_inc = {1'b0, elapsed_q} + 17'd1;
    neg_mag     = 17'h10000 - {1'b0, item_i.mic_sample};
    if (item_i.mic_sample[cst_pkg::SampleW-1]) begin
      // the most negative sample clips to full scale
      mag = (neg_mag > 17'h07FFF) ? 15'h7FFF : neg_mag[cst_pkg::MagW-1:0];
    end else begin
      mag = item_i.mic_sample[cst_pkg::MagW-1:0];
    end
    peak_max  = (mag > peak_q) ? mag : peak_q;
    frame_lvl = peak_max[cst_pkg::MagW-1:cst_pkg::PeakShift];

    if (fire_i) begin
      case (item_i.cmd)
        cst_pkg::CmdCall: begin
          call_ind_d = item_i.indicator_value;
          rederive   = 1'b1;
        end
        cst_pkg::CmdSetup: begin
          setup_ind_d = item_i.indicator_value;
          rederive    = 1'b1;
        end
        cst_pkg::CmdDisconnect: begin
          call_ind_d  = '0;
          setup_ind_d = '0;
          rederive    = 1'b1;
        end
        cst_pkg::CmdTick: begin
          if (state_q == cst_pkg::StActive) begin
            if (elapsed_inc >= cst_pkg::MsPerSecond) begin
              elapsed_d = '0;
              if (seconds_q < cst_pkg::SecondsMax) begin
                seconds_d = seconds_q + 20'd1;
              end
            end else begin
              elapsed_d = elapsed_inc[cst_pkg::MsW-1:0];
            end
          end else if (state_q == cst_pkg::StEnded) begin
            if (elapsed_q >= hold_q) begin
              state_d   = cst_pkg::StIdle;
              elapsed_d = '0;
              seconds_d = '0;
            end else begin
              elapsed_d = elapsed_inc[cst_pkg::MsW-1:0];
            end
          end
        end
        cst_pkg::CmdSample: begin
          peak_d = peak_max;
          if (item_i.frame_end) begin
            if (frame_lvl > meter_q) begin
              meter_d = frame_lvl;
            end else begin
              meter_d = meter_q - (meter_q >> cst_pkg::DecayShift);
            end
            peak_d = '0;
          end
        end
        default: begin
        end
      endcase
    end

    if (rederive) begin
      if (call_ind_d != '0) begin
        derived = cst_pkg::StActive;
      end else if (setup_ind_d == 2'd1) begin
        derived = cst_pkg::StIncoming;
      end else if (setup_ind_d != 2'd0) begin
        derived = cst_pkg::StOutgoing;
      end else if (state_q == cst_pkg::StActive || state_q == cst_pkg::StOutgoing ||
                   state_q == cst_pkg::StIncoming) begin
        derived = cst_pkg::StEnded;
      end else begin
        derived = cst_pkg::StIdle;
      end
      if (derived != state_q) begin
        state_d = derived;
        if (derived == cst_pkg::StActive || derived == cst_pkg::StIdle) begin
          seconds_d = '0;
          elapsed_d = '0;
        end
        if (derived == cst_pkg::StEnded) begin
          elapsed_d = '0;
        end
      end
    end
  end

  assign result_o.call_state   = state_d;
  assign result_o.call_seconds = (state_d == cst_pkg::StIdle) ? '0 : seconds_d;
  assign result_o.mic_level    = (state_d == cst_pkg::StActive) ? meter_d : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q      <= cst_pkg::HoldReset;
      call_ind_q  <= '0;
      setup_ind_q <= '0;
      state_q     <= cst_pkg::StIdle;
      elapsed_q   <= '0;
      seconds_q   <= '0;
      peak_q      <= '0;
      meter_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        hold_q <= cfg_wdata_i;
      end
      call_ind_q  <= call_ind_d;
      setup_ind_q <= setup_ind_d;
      state_q     <= state_d;
      elapsed_q   <= elapsed_d;
      seconds_q   <= seconds_d;
      peak_q      <= peak_d;
      meter_q     <= meter_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cst_out_stage.sv =====
`default_nettype none

module cst_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire cst_pkg::result_t result_i,
  output logic                  space_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output cst_pkg::result_t      result_o
);

  logic             valid_q;
  cst_pkg::result_t result_q;

  assign space_o  = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (space_o && load_i) begin
      result_q <= result_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/call_state_tracker_unit.sv =====
`default_nettype none

// Hands-free call state tracker. Each transaction on the slave stream is one
// event (tuser = command: call indicator, setup indicator, disconnect,
// millisecond tick, mic sample) and yields exactly one result on the master
// stream: call state, whole seconds of the active call and the mic peak
// level. One transaction is accepted every cycle unless the input side is
// stalled; a result passes from the input register through one pass of
// state-update logic into the result register. Backpressure on the master
// side stalls the input side only once both registers are full. The user
// must set the hold time of the ended state through cfg_we_i/cfg_wdata_i
// only while the stream is quiet; the block itself does not enforce it.
module call_state_tracker_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // [1:0] indicator_value, [17:2] mic_sample
  input  wire logic [2:0]  s_axis_tuser,  // [2:0] cmd
  input  wire logic        s_axis_tlast,  // frame_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata   // [2:0] call_state, [22:3] call_seconds,
                                          // [30:23] mic_level
);

  cst_pkg::item_t   in_item;
  cst_pkg::item_t   stage_item;
  cst_pkg::result_t core_result;
  cst_pkg::result_t out_result;
  logic             stage_valid;
  logic             out_space;
  logic             advance;

  assign in_item.cmd             = s_axis_tuser;
  assign in_item.indicator_value = s_axis_tdata[1:0];
  assign in_item.mic_sample      = s_axis_tdata[17:2];
  assign in_item.frame_end       = s_axis_tlast;

  assign advance = stage_valid && out_space;

  cst_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (stage_valid),
    .item_o    (stage_item)
  );

  cst_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .item_i      (stage_item),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (core_result)
  );

  cst_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (stage_valid),
    .result_i (core_result),
    .space_o  (out_space),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_result)
  );

  assign m_axis_tdata = {1'b0, out_result.mic_level, out_result.call_seconds,
                         out_result.call_state};

`ifndef ASSERT_OFF
  // a registered item always moves on when the result register has room
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid && out_space) |=> m_axis_tvalid)
    else $error("item in input register not transferred to result register");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[2:0] == cst_pkg::StIdle) |-> m_axis_tdata[22:3] == '0)
    else $error("seconds reported while idle");

  a_level_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[30:23] != '0) |-> m_axis_tdata[2:0] == cst_pkg::StActive)
    else $error("mic level reported outside active call");
`endif

endmodule

`default_nettype wire
